### hdl/tpt_pkg.sv
package tpt_pkg;

   localparam int CNT_W      = 7;
   localparam int CNT_LIMIT  = 64;
   localparam int DATA_W     = 32;
   localparam int NUM_W      = 17;
   localparam int DEN_W      = 14;
   localparam int OP_W       = 33;
   localparam int PROD_W     = OP_W + NUM_W;
   localparam int MAG_W      = 48;
   localparam int REM_W      = MAG_W - DATA_W;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DATA_W / DIV_BITS;
   localparam int LANE_LAT   = DIV_STAGES + 2;
   localparam int NUM_AXES   = 6;

   typedef struct packed {
      logic [CNT_W-1:0]                 index;
      logic [CNT_W-1:0]                 count;
      logic                             last;
      logic signed [NUM_W-1:0]          num;
      logic [DEN_W-1:0]                 den;
      logic [NUM_AXES-1:0][DATA_W-1:0]  target;
      logic [DATA_W-1:0]                move_time;
   } job_type;

   function automatic logic [DATA_W-1:0] sat_result(input logic [DATA_W-1:0] quo,
                                                     input logic neg, input logic ovf);
      logic [DATA_W-1:0] res;
      if (ovf) begin
         res = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else if (!neg) begin
         res = quo[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : quo;
      end else begin
         res = (quo[DATA_W-1] && (quo[DATA_W-2:0] != '0)) ?
               {1'b1, {(DATA_W-1){1'b0}}} : (~quo + 1'b1);
      end
      return res;
   endfunction

endpackage

### hdl/tpt_seq.sv
module tpt_seq (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [tpt_pkg::NUM_AXES-1:0][tpt_pkg::DATA_W-1:0] target,
   input  logic [tpt_pkg::DATA_W-1:0]                   move_time,
   input  logic [tpt_pkg::CNT_W-1:0]                    segment_count,
   output logic                                         job_valid,
   output tpt_pkg::job_type                             job
);
   import tpt_pkg::*;

   logic                                busy_ff, busy_in;
   logic [CNT_W-1:0]                    cnt_ff, idx_ff;
   logic [NUM_AXES-1:0][DATA_W-1:0]     tgt_ff;
   logic [DATA_W-1:0]                   time_ff;
   logic                                job_valid_ff;
   job_type                             job_ff, job_in;
   logic [CNT_W-1:0]                    cnt_clamp;
   logic [2*CNT_W-1:0]                  ii, nn, inn;
   logic signed [19:0]                  ii_s, nn_s, inn_s, i_s, n_s;
   logic signed [19:0]                  num1, num2, num3;
   logic [CNT_W-1:0]                    k, q1, q3;
   logic [CNT_W+1:0]                    n3;

   assign cnt_clamp = (segment_count > CNT_W'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT) : segment_count;
   assign req_ready = !busy_ff;

   always_comb begin
      ii    = idx_ff * idx_ff;
      nn    = cnt_ff * cnt_ff;
      inn   = idx_ff * cnt_ff;
      ii_s  = $signed({6'd0, ii});
      nn_s  = $signed({6'd0, nn});
      inn_s = $signed({6'd0, inn});
      i_s   = $signed({13'd0, idx_ff});
      n_s   = $signed({13'd0, cnt_ff});
      num1  = ii_s <<< 3;
      num2  = (i_s <<< 3) - n_s;
      num3  = (inn_s <<< 4) - (nn_s * 20'sd5) - (ii_s <<< 3);
      k     = idx_ff - 1'b1;
      q1    = cnt_ff >> 2;
      n3    = {2'b00, cnt_ff} + {1'b0, cnt_ff, 1'b0};
      q3    = n3[CNT_W+1:2];
      job_in.index     = idx_ff;
      job_in.count     = cnt_ff;
      job_in.last      = (idx_ff == cnt_ff);
      job_in.target    = tgt_ff;
      job_in.move_time = time_ff;
      if (k < q1) begin
         job_in.num = num1[NUM_W-1:0];
         job_in.den = DEN_W'(nn * 2'd3);
      end else if (k < q3) begin
         job_in.num = num2[NUM_W-1:0];
         job_in.den = DEN_W'(cnt_ff) * DEN_W'(6);
      end else begin
         job_in.num = num3[NUM_W-1:0];
         job_in.den = DEN_W'(nn * 2'd3);
      end
      busy_in = busy_ff;
      if (busy_ff && advance && (idx_ff == cnt_ff)) begin
         busy_in = 1'b0;
      end else if (req_valid && !busy_ff) begin
         busy_in = (cnt_clamp != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (advance) begin
            job_valid_ff <= busy_ff;
         end
      end
      if (req_valid && !busy_ff) begin
         tgt_ff  <= target;
         time_ff <= move_time;
         cnt_ff  <= cnt_clamp;
         idx_ff  <= CNT_W'(1);
      end else if (busy_ff && advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (advance) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

### hdl/tpt_div_lane.sv
module tpt_div_lane (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [tpt_pkg::OP_W-1:0]    op,
   input  logic signed [tpt_pkg::NUM_W-1:0]   fac,
   input  logic [tpt_pkg::DEN_W-1:0]          den,
   output logic [tpt_pkg::DATA_W-1:0]         quo,
   output logic                               neg,
   output logic                               ovf
);
   import tpt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic [DEN_W-1:0]         mden_ff;
   logic [PROD_W-1:0]        abs_prod;
   logic [MAG_W-1:0]         mag;

   logic [REM_W-1:0]  rem_ff [0:DIV_STAGES];
   logic [DATA_W-1:0] low_ff [0:DIV_STAGES];
   logic [DATA_W-1:0] quo_ff [0:DIV_STAGES];
   logic [DEN_W-1:0]  den_ff [0:DIV_STAGES];
   logic              neg_ff [0:DIV_STAGES];
   logic              ovf_ff [0:DIV_STAGES];

   always_comb begin
      abs_prod = prod_ff[PROD_W-1] ? (~prod_ff + 1'b1) : prod_ff;
      mag      = abs_prod[MAG_W-1:0] + MAG_W'(mden_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= op * fac;
         mden_ff   <= den;
         rem_ff[0] <= mag[MAG_W-1:DATA_W];
         low_ff[0] <= mag[DATA_W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= mden_ff;
         neg_ff[0] <= prod_ff[PROD_W-1];
         ovf_ff[0] <= (mag[MAG_W-1:DATA_W] >= REM_W'(mden_ff));
      end
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [DATA_W-1:0] low_in, quo_in;

      always_comb begin
         logic [REM_W-1:0] r;
         r      = rem_ff[s];
         low_in = low_ff[s];
         quo_in = quo_ff[s];
         for (int b = 0; b < DIV_BITS; b++) begin
            r      = {r[REM_W-2:0], low_in[DATA_W-1]};
            low_in = {low_in[DATA_W-2:0], 1'b0};
            if (r >= REM_W'(den_ff[s])) begin
               r      = r - REM_W'(den_ff[s]);
               quo_in = {quo_in[DATA_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[DATA_W-2:0], 1'b0};
            end
         end
         rem_in = r;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= rem_in;
            low_ff[s+1] <= low_in;
            quo_ff[s+1] <= quo_in;
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES];
   assign neg = neg_ff[DIV_STAGES];
   assign ovf = ovf_ff[DIV_STAGES];

endmodule

### hdl/trapezoid_profile_trajectory_unit.sv
// Trapezoidal velocity profile generator.
// A request on the req_ channel carries target x, y, z, roll, pitch, yaw,
// a move time and a segment count N (clamped to 64). It is answered by N
// points on the rsp_ channel, numbered from one, each with the step time,
// the profiled positions, the interpolated angles and a flag on the last.
// A request with a count of zero is taken and answers nothing.
// Points leave one per cycle while rsp_ready is high. After the request is
// accepted, each point passes the issue register, the multiplier stage, the
// rounding stage, eight four-bit stages of its lane's own divider and the
// output register.
// A request of N points holds req_ready low while its N points are issued,
// so no new request is taken before the last point of the old one issues.
// When rsp_valid is high and rsp_ready low the whole pipeline holds; nothing
// is lost or repeated. Synchronous reset empties the pipeline, idles the block.
module trapezoid_profile_trajectory_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_target_x,
   input  logic signed [31:0]            req_target_y,
   input  logic signed [31:0]            req_target_z,
   input  logic signed [31:0]            req_target_roll,
   input  logic signed [31:0]            req_target_pitch,
   input  logic signed [31:0]            req_target_yaw,
   input  logic [31:0]                   req_move_time,
   input  logic [6:0]                    req_segment_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [6:0]                    rsp_point_index,
   output logic [31:0]                   rsp_step_time,
   output logic signed [31:0]            rsp_pos_x,
   output logic signed [31:0]            rsp_pos_y,
   output logic signed [31:0]            rsp_pos_z,
   output logic signed [31:0]            rsp_ang_roll,
   output logic signed [31:0]            rsp_ang_pitch,
   output logic signed [31:0]            rsp_ang_yaw,
   output logic                          rsp_last_point
);
   import tpt_pkg::*;

   logic                             advance;
   logic                             job_valid;
   job_type                          job;
   logic [NUM_AXES-1:0][DATA_W-1:0]  target;
   logic [NUM_AXES-1:0][DATA_W-1:0]  lane_quo;
   logic [NUM_AXES-1:0]              lane_neg, lane_ovf;
   logic [DATA_W-1:0]                dt_quo;
   logic                             dt_neg, dt_ovf;

   logic                  mv_ff   [0:LANE_LAT-1];
   logic [CNT_W-1:0]      midx_ff [0:LANE_LAT-1];
   logic                  mlast_ff[0:LANE_LAT-1];

   logic                  rsp_valid_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [DATA_W-1:0]     dt_ff;
   logic [NUM_AXES-1:0][DATA_W-1:0] res_ff;
   logic                  last_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign target  = {req_target_yaw, req_target_pitch, req_target_roll,
                     req_target_z, req_target_y, req_target_x};

   tpt_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .target        (target),
      .move_time     (req_move_time),
      .segment_count (req_segment_count),
      .job_valid     (job_valid),
      .job           (job)
   );

   for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
      logic signed [NUM_W-1:0] fac;
      logic [DEN_W-1:0]        den;
      assign fac = (j < 3) ? job.num : $signed({{(NUM_W-CNT_W){1'b0}}, job.index});
      assign den = (j < 3) ? job.den : DEN_W'(job.count);
      tpt_div_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .op      ($signed({job.target[j][DATA_W-1], job.target[j]})),
         .fac     (fac),
         .den     (den),
         .quo     (lane_quo[j]),
         .neg     (lane_neg[j]),
         .ovf     (lane_ovf[j])
      );
   end

   tpt_div_lane u_dt (
      .clock   (clock),
      .advance (advance),
      .op      ($signed({1'b0, job.move_time})),
      .fac     (NUM_W'(1)),
      .den     (DEN_W'(job.count)),
      .quo     (dt_quo),
      .neg     (dt_neg),
      .ovf     (dt_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            mv_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mv_ff[0] <= job_valid;
         for (int s = 1; s < LANE_LAT; s++) begin
            mv_ff[s] <= mv_ff[s-1];
         end
         rsp_valid_ff <= mv_ff[LANE_LAT-1];
      end
      if (advance) begin
         midx_ff[0]  <= job.index;
         mlast_ff[0] <= job.last;
         for (int s = 1; s < LANE_LAT; s++) begin
            midx_ff[s]  <= midx_ff[s-1];
            mlast_ff[s] <= mlast_ff[s-1];
         end
         idx_ff  <= midx_ff[LANE_LAT-1];
         last_ff <= mlast_ff[LANE_LAT-1];
         dt_ff   <= (dt_neg || dt_ovf) ? '0 : dt_quo;
         for (int j = 0; j < NUM_AXES; j++) begin
            res_ff[j] <= sat_result(lane_quo[j], lane_neg[j], lane_ovf[j]);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = idx_ff;
   assign rsp_step_time   = dt_ff;
   assign rsp_pos_x       = res_ff[0];
   assign rsp_pos_y       = res_ff[1];
   assign rsp_pos_z       = res_ff[2];
   assign rsp_ang_roll    = res_ff[3];
   assign rsp_ang_pitch   = res_ff[4];
   assign rsp_ang_yaw     = res_ff[5];
   assign rsp_last_point  = last_ff;

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_segment_count != '0)) |=> !req_ready)
      else $error("request with points did not make the block busy");

   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_index != '0))
      else $error("point index zero on a valid point");

   a_index_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_index <= CNT_W'(CNT_LIMIT)))
      else $error("point index beyond the count limit");

endmodule
